// ===== hw/rtl/atat_pkg.sv =====
// Package for the tilt-angle tracker: sizes, event codes and the arctangent table.
// No dependencies.
`default_nettype none
package atat_pkg;
   localparam int AXIS_COUNT   = 3;
   localparam int AXIS_W       = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W       = 5;
   localparam int DP_W         = 68;   // working width of the x/y datapath
   localparam int Z_W          = 30;
   localparam logic [15:0] ABS_EVENT_TYPE = 16'd3;
   localparam logic signed [Z_W-1:0] DEG90_Z  = 30'sd94371840;
   localparam logic signed [Z_W-1:0] DEG180_Z = 30'sd188743680;

   function automatic logic signed [Z_W-1:0] atan_z(input logic [STEP_W-1:0] i);
      logic signed [Z_W-1:0] r;
      case (i)
         5'd0: r = 30'sd47185920;  5'd1: r = 30'sd27855475;
         5'd2: r = 30'sd14718068;  5'd3: r = 30'sd7471121;
         5'd4: r = 30'sd3750058;   5'd5: r = 30'sd1876857;
         5'd6: r = 30'sd938658;    5'd7: r = 30'sd469357;
         5'd8: r = 30'sd234682;    5'd9: r = 30'sd117342;
         5'd10: r = 30'sd58671;    5'd11: r = 30'sd29335;
         5'd12: r = 30'sd14668;    5'd13: r = 30'sd7334;
         5'd14: r = 30'sd3667;     5'd15: r = 30'sd1833;
         5'd16: r = 30'sd917;      5'd17: r = 30'sd458;
         5'd18: r = 30'sd229;      5'd19: r = 30'sd115;
         5'd20: r = 30'sd57;       5'd21: r = 30'sd29;
         5'd22: r = 30'sd14;       5'd23: r = 30'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/atat_if.sv =====
// Valid/ready channel interfaces for event items and result items.
// Depends on nothing.
`default_nettype none
interface atat_req_if (input wire logic clock);
   logic               valid;
   logic               ready;
   logic [15:0]        event_type;
   logic [15:0]        event_code;
   logic signed [15:0] event_value;
   modport source (output valid, event_type, event_code, event_value, input ready);
   modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface atat_rsp_if (input wire logic clock);
   logic               valid;
   logic               ready;
   logic [2:0]         axis_number;
   logic signed [15:0] acceleration;
   logic               angle_valid;
   logic [13:0]        gravity_angle;
   modport source (output valid, axis_number, acceleration, angle_valid, gravity_angle,
                   input ready);
   modport sink   (input valid, axis_number, acceleration, angle_valid, gravity_angle,
                   output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/accel_tilt_angle_tracker_core.sv =====
// Tilt-angle tracker top level: axis store, sum of squares, root and CORDIC sequencer.
// Depends on atat_pkg and the interfaces in atat_if.sv.
`default_nettype none
// An absolute-axis event (type 3, code below the axis count) updates that axis and gives
// one result: the reading and, once every axis has been seen and the magnitude is
// nonzero, the angle to gravity in 1/64 degree. Other events are taken and give
// nothing. A kept event with a valid angle passes through three sum-of-squares steps,
// one normalise step, the 32 steps of the bit-serial square root, the 24 CORDIC steps
// and a final clamp and round before its result is valid. Without a valid angle the
// result follows the normalise step directly. The result is held until the handshake
// takes it. The input is not ready while an item is at work or its result waits.
module accel_tilt_angle_tracker_core
   import atat_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   atat_req_if.sink   req,
   atat_rsp_if.source rsp
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001, ST_SUM = 7'b0000010, ST_NORM = 7'b0000100,
      ST_ROOT = 7'b0001000, ST_ROT = 7'b0010000, ST_FIN = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [15:0] rdg_ff [AXIS_COUNT];
   logic [AXIS_COUNT-1:0] seen_ff;
   logic [AXIS_W-1:0] axis_ff, idx_ff;
   logic signed [15:0] val_ff;
   logic [63:0] s_ff, n_ff, r_ff, b_ff;
   logic [4:0] k_ff;
   logic [STEP_W:0] cnt_ff;
   logic signed [DP_W-1:0] x_ff, y_ff;
   logic signed [Z_W-1:0] z_ff;
   logic ok_ff;
   logic [13:0] ang_ff;

   wire accept = req.valid && req.ready;
   wire keep   = req.event_type == ABS_EVENT_TYPE && req.event_code < 16'(AXIS_COUNT);
   assign req.ready = state_ff == ST_IDLE;

   logic signed [31:0] sq;
   logic signed [31:0] vsq;
   assign sq  = rdg_ff[idx_ff] * rdg_ff[idx_ff];
   assign vsq = val_ff * val_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && keep) state_in = ST_SUM;
         ST_SUM:  if (32'(idx_ff) == AXIS_COUNT-1) state_in = ST_NORM;
         ST_NORM: state_in = (&seen_ff && s_ff != 0) ? ST_ROOT : ST_OUT;
         ST_ROOT: if (b_ff[1:0] != 2'b00 || b_ff == 0) state_in = ST_ROT;
         ST_ROT:  if (cnt_ff == 6'(CORDIC_STEPS-1)) state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic signed [DP_W-1:0] dx, dy;
   logic [4:0] shamt;
   assign shamt = cnt_ff[4:0];
   assign dx = y_ff >>> shamt;
   assign dy = x_ff >>> shamt;
   logic [63:0] rb;
   assign rb = r_ff + b_ff;

   // final root step result (one more step when b is at its last nonzero value)
   function automatic logic [63:0] rb_fin(input logic [63:0] n, input logic [63:0] r,
                                          input logic [63:0] b);
      logic [63:0] rr;
      rr = r;
      if (b != 0) rr = (n >= r + b) ? (r >> 1) + b : r >> 1;
      return rr;
   endfunction

   // k: largest in 0..31 with S*4^k < 2^62
   function automatic logic [4:0] norm_k(input logic [63:0] s);
      logic [4:0] k;
      k = 5'd0;
      for (int j = 1; j < 32; j++)
         if (s < (64'd1 << (62 - 2*j))) k = 5'(j);
      return k;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (accept && keep) begin
               rdg_ff[req.event_code[AXIS_W-1:0]] <= req.event_value;
               seen_ff[req.event_code[AXIS_W-1:0]] <= 1'b1;
               axis_ff <= req.event_code[AXIS_W-1:0];
               val_ff  <= req.event_value;
               idx_ff  <= '0;
               s_ff    <= '0;
            end
            ST_SUM: begin
               if (seen_ff[idx_ff]) s_ff <= s_ff + 64'(unsigned'(sq));
               idx_ff <= idx_ff + 1'b1;
            end
            ST_NORM: begin
               k_ff <= norm_k(s_ff);
               n_ff <= (s_ff - 64'(unsigned'(vsq))) << (2*norm_k(s_ff));
               r_ff <= '0;
               b_ff <= 64'h4000_0000_0000_0000;
               ok_ff <= &seen_ff && s_ff != 0;
            end
            ST_ROOT: begin
               if (b_ff != 0) begin
                  if (n_ff >= rb) begin
                     n_ff <= n_ff - rb;
                     r_ff <= (r_ff >> 1) + b_ff;
                  end else
                     r_ff <= r_ff >> 1;
                  b_ff <= b_ff >> 2;
               end
               if (b_ff[1:0] != 2'b00 || b_ff == 0) begin
                  cnt_ff <= '0;
                  if (val_ff < 0) begin
                     x_ff <= DP_W'(rb_fin(n_ff, r_ff, b_ff));
                     y_ff <= -(DP_W'(val_ff) <<< k_ff);
                     z_ff <= DEG90_Z;
                  end else begin
                     x_ff <= DP_W'(val_ff) <<< k_ff;
                     y_ff <= DP_W'(rb_fin(n_ff, r_ff, b_ff));
                     z_ff <= '0;
                  end
               end
            end
            ST_ROT: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + atan_z(shamt);
               end else begin
                  x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - atan_z(shamt);
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_FIN: begin
               if (z_ff < 0) ang_ff <= '0;
               else if (z_ff > DEG180_Z) ang_ff <= 14'd11520;
               else ang_ff <= 14'((z_ff + 30'sd8192) >>> 14);
            end
            ST_OUT: ;
            default: ;
         endcase
         if (state_ff == ST_NORM && !(&seen_ff && s_ff != 0)) ang_ff <= '0;
      end
   end

   assign rsp.valid         = state_ff == ST_OUT;
   assign rsp.axis_number   = 3'(axis_ff);
   assign rsp.acceleration  = val_ff;
   assign rsp.angle_valid   = ok_ff;
   assign rsp.gravity_angle = ok_ff ? ang_ff : 14'd0;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.gravity_angle))
      else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.gravity_angle <= 14'd11520) else $error("angle range");
   a_seen: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.angle_valid |-> &seen_ff) else $error("angle without all axes");
endmodule
`default_nettype wire
